/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check that prop holds at every rising edge of clk outside reset.
`define CHK_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Check that expr never holds at a rising edge of clk outside reset.
`define CHK_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);
`else
`define CHK_ASSERT(lbl, clk, rstn, prop, msg)
`define CHK_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

/* hw/rtl/bscfz_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bscfz_pkg;

    localparam int DEF_BITMAP_WORDS = 128;
    localparam int WORD_W           = 32;
    localparam int POS_W            = 5;
    localparam int INDEX_W          = 12;
    localparam int LIMIT_W          = 13;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

    typedef enum logic [1:0] {
        REQ_SET    = 2'd0,
        REQ_CLEAR  = 2'd1,
        REQ_TOGGLE = 2'd2,
        REQ_FIND   = 2'd3
    } t_req_e;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_DONE
    } t_state_e;

    typedef struct packed {
        logic [WORD_W-1:0] new_word;
        logic              old_bit;
        logic              full;
        logic [POS_W-1:0]  zero_pos;
    } t_word_res;

endpackage

`default_nettype wire

/* hw/rtl/bitmap_set_clear_find_zero.sv */
// Bitmap of BITMAP_WORDS 32-bit words with set, clear, toggle and
// find-next-zero requests.
// Input channel: i_in_valid / o_in_stall carry i_req_type and i_bit_index.
// Output channel: o_out_valid / i_out_stall carry o_old_bit and
// o_zero_index, one result per request. Config channel: i_cfg_valid /
// o_cfg_ready write i_search_limit, taken in any cycle while idle; a limit
// written in the cycle of an input transfer applies to that request.
// Set, clear and toggle pass through a read of the word RAM, one
// read-modify-write through the word unit, and the result stage; an index
// past the bitmap skips the write. A search costs, for each word it scans,
// one RAM read plus one pass of the shared word unit. A search that starts
// at or past the limit goes from the RAM read straight to the result stage.
// One request is in flight at a time; the next transfer is taken once the
// result has moved to the output register, so o_in_stall stays high while
// a request is in work.
// After reset the block sweeps the RAM to zero, one word a cycle, through
// all BITMAP_WORDS words; o_in_stall stays high meanwhile. search_limit resets
// to 4096. A stalled result holds in the output register, and the block
// can accept and work one more request, whose result then waits until
// the output register frees.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bitmap_set_clear_find_zero #(
    parameter int BITMAP_WORDS = bscfz_pkg::DEF_BITMAP_WORDS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output      logic                          o_in_stall,
    input  wire logic [1:0]                    i_req_type,
    input  wire logic [bscfz_pkg::INDEX_W-1:0] i_bit_index,
    output      logic                          o_out_valid,
    input  wire logic                          i_out_stall,
    output      logic                          o_old_bit,
    output      logic [bscfz_pkg::LIMIT_W-1:0] o_zero_index,
    input  wire logic                          i_cfg_valid,
    output      logic                          o_cfg_ready,
    input  wire logic [bscfz_pkg::LIMIT_W-1:0] i_search_limit
);

    localparam int AW         = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int TOTAL_BITS = BITMAP_WORDS * bscfz_pkg::WORD_W;
    localparam int IDX_W      = bscfz_pkg::LIMIT_W + 1;
    localparam int WIDX_W     = IDX_W - bscfz_pkg::POS_W;

    bscfz_pkg::t_state_e r_state, n_state;
    logic [AW-1:0]       r_clr_cnt, n_clr_cnt;
    logic                r_out_valid, n_out_valid;
    logic [bscfz_pkg::LIMIT_W-1:0] r_limit, n_limit;

    bscfz_pkg::t_req_e             r_req, n_req;
    logic [IDX_W-1:0]              r_idx, n_idx;
    logic [bscfz_pkg::LIMIT_W-1:0] r_end, n_end;
    logic                          r_res_old, n_res_old;
    logic [bscfz_pkg::LIMIT_W-1:0] r_res_zi, n_res_zi;
    logic                          r_old_bit, n_old_bit;
    logic [bscfz_pkg::LIMIT_W-1:0] r_zero_index, n_zero_index;

    logic [bscfz_pkg::WORD_W-1:0] r_mem [BITMAP_WORDS];
    logic [bscfz_pkg::WORD_W-1:0] r_rdata;
    logic                         w_mem_we;
    logic [AW-1:0]                w_mem_addr;
    logic [bscfz_pkg::WORD_W-1:0] w_mem_wdata;

    bscfz_pkg::t_word_res          w_res;
    logic                          w_is_find;
    logic                          w_past_end;
    logic                          w_in_range;
    logic                          w_out_free;
    logic                          w_clr_last;
    logic [bscfz_pkg::LIMIT_W-1:0] w_hit;

    bscfz_word_unit u_word_unit (
        .i_word    (r_rdata),
        .i_bit_pos (r_idx[bscfz_pkg::POS_W-1:0]),
        .i_req     (r_req),
        .o_res     (w_res)
    );

    assign w_is_find  = (r_req == bscfz_pkg::REQ_FIND);
    assign w_past_end = (r_idx >= {1'b0, r_end});
    assign w_in_range = ({25'd0, r_idx[bscfz_pkg::INDEX_W-1:bscfz_pkg::POS_W]}
                         < 32'(BITMAP_WORDS));
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_clr_last = (r_clr_cnt == AW'(BITMAP_WORDS - 1));
    assign w_hit      = {r_idx[bscfz_pkg::LIMIT_W-1:bscfz_pkg::POS_W], w_res.zero_pos};

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bscfz_pkg::ST_CLEAR: begin
                if (w_clr_last) n_state = bscfz_pkg::ST_IDLE;
            end
            bscfz_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = bscfz_pkg::ST_READ;
            end
            bscfz_pkg::ST_READ: begin
                if (w_is_find) begin
                    n_state = w_past_end ? bscfz_pkg::ST_DONE : bscfz_pkg::ST_EXEC;
                end else begin
                    n_state = w_in_range ? bscfz_pkg::ST_EXEC : bscfz_pkg::ST_DONE;
                end
            end
            bscfz_pkg::ST_EXEC: begin
                if (w_is_find && w_res.full) n_state = bscfz_pkg::ST_READ;
                else                         n_state = bscfz_pkg::ST_DONE;
            end
            bscfz_pkg::ST_DONE: begin
                if (w_out_free) n_state = bscfz_pkg::ST_IDLE;
            end
            default: n_state = bscfz_pkg::ST_CLEAR;
        endcase
    end

    // Handshake and RAM controls
    always_comb begin
        o_in_stall  = (r_state != bscfz_pkg::ST_IDLE);
        o_cfg_ready = (r_state == bscfz_pkg::ST_IDLE);
        w_mem_we    = 1'b0;
        w_mem_addr  = AW'(r_idx[IDX_W-1:bscfz_pkg::POS_W]);
        w_mem_wdata = w_res.new_word;
        case (r_state)
            bscfz_pkg::ST_CLEAR: begin
                w_mem_we    = 1'b1;
                w_mem_addr  = r_clr_cnt;
                w_mem_wdata = '0;
            end
            bscfz_pkg::ST_EXEC: begin
                w_mem_we = !w_is_find;
            end
            default: begin
                w_mem_we = 1'b0;
            end
        endcase
    end

    // Datapath next values
    always_comb begin
        n_clr_cnt    = r_clr_cnt;
        n_out_valid  = r_out_valid;
        n_limit      = r_limit;
        n_req        = r_req;
        n_idx        = r_idx;
        n_end        = r_end;
        n_res_old    = r_res_old;
        n_res_zi     = r_res_zi;
        n_old_bit    = r_old_bit;
        n_zero_index = r_zero_index;

        if (i_cfg_valid && o_cfg_ready) n_limit = i_search_limit;
        if (r_out_valid && !i_out_stall) n_out_valid = 1'b0;

        case (r_state)
            bscfz_pkg::ST_CLEAR: begin
                n_clr_cnt = r_clr_cnt + AW'(1);
            end
            bscfz_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_req     = bscfz_pkg::t_req_e'(i_req_type);
                    n_idx     = {2'b00, i_bit_index};
                    n_end     = ({19'd0, n_limit} < 32'(TOTAL_BITS))
                                ? n_limit : bscfz_pkg::LIMIT_W'(TOTAL_BITS);
                    n_res_old = 1'b0;
                    n_res_zi  = '0;
                end
            end
            bscfz_pkg::ST_READ: begin
                if (w_is_find && w_past_end) n_res_zi = r_limit;
            end
            bscfz_pkg::ST_EXEC: begin
                if (!w_is_find) begin
                    n_res_old = w_res.old_bit;
                end else if (!w_res.full) begin
                    n_res_zi = ({1'b0, w_hit} < {1'b0, r_end}) ? w_hit : r_limit;
                end else begin
                    // Advance to the start of the next word
                    n_idx = {r_idx[IDX_W-1:bscfz_pkg::POS_W] + WIDX_W'(1),
                             bscfz_pkg::POS_W'(0)};
                end
            end
            bscfz_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_old_bit    = r_res_old;
                    n_zero_index = r_res_zi;
                end
            end
            default: begin
                n_clr_cnt = r_clr_cnt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bscfz_pkg::ST_CLEAR;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
            r_limit     <= bscfz_pkg::LIMIT_RESET;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_out_valid <= n_out_valid;
            r_limit     <= n_limit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_idx        <= n_idx;
        r_end        <= n_end;
        r_res_old    <= n_res_old;
        r_res_zi     <= n_res_zi;
        r_old_bit    <= n_old_bit;
        r_zero_index <= n_zero_index;
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) r_mem[w_mem_addr] <= w_mem_wdata;
        r_rdata <= r_mem[w_mem_addr];
    end

    assign o_out_valid  = r_out_valid;
    assign o_old_bit    = r_old_bit;
    assign o_zero_index = r_zero_index;

    `CHK_ASSERT(a_we_legal, i_clk, i_rst_n, w_mem_we |-> (r_state == bscfz_pkg::ST_CLEAR || (r_state == bscfz_pkg::ST_EXEC && !w_is_find)), "RAM written outside clear sweep or modify")
    `CHK_ASSERT(a_clear_ends, i_clk, i_rst_n, (r_state == bscfz_pkg::ST_CLEAR && w_clr_last) |=> (r_state == bscfz_pkg::ST_IDLE), "clear sweep did not end in idle")
    `CHK_ASSERT(a_load_from_done, i_clk, i_rst_n, $rose(r_out_valid) |-> ($past(r_state) == bscfz_pkg::ST_DONE), "result loaded outside done state")
    `CHK_ASSERT(a_scan_aligned, i_clk, i_rst_n, (r_state == bscfz_pkg::ST_EXEC && w_is_find && w_res.full) |=> (r_idx[bscfz_pkg::POS_W-1:0] == '0), "scan advance not word aligned")

endmodule

`default_nettype wire

/* hw/rtl/bscfz_word_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

module bscfz_word_unit (
    input  wire logic [bscfz_pkg::WORD_W-1:0] i_word,
    input  wire logic [bscfz_pkg::POS_W-1:0]  i_bit_pos,
    input  wire bscfz_pkg::t_req_e            i_req,
    output bscfz_pkg::t_word_res              o_res
);

    logic [bscfz_pkg::WORD_W-1:0] w_bit_mask;
    logic [bscfz_pkg::WORD_W-1:0] w_masked;
    logic [bscfz_pkg::POS_W-1:0]  w_pos;

    assign w_bit_mask = bscfz_pkg::WORD_W'(1) << i_bit_pos;
    // Treat bits below the start position as taken.
    assign w_masked   = i_word | (w_bit_mask - bscfz_pkg::WORD_W'(1));

    always_comb begin
        w_pos = '0;
        for (int i = bscfz_pkg::WORD_W - 1; i >= 0; i--) begin
            if (!w_masked[i]) begin
                w_pos = bscfz_pkg::POS_W'(i);
            end
        end
    end

    always_comb begin
        case (i_req)
            bscfz_pkg::REQ_SET:    o_res.new_word = i_word | w_bit_mask;
            bscfz_pkg::REQ_CLEAR:  o_res.new_word = i_word & ~w_bit_mask;
            bscfz_pkg::REQ_TOGGLE: o_res.new_word = i_word ^ w_bit_mask;
            default:               o_res.new_word = i_word;
        endcase
        o_res.old_bit  = i_word[i_bit_pos];
        o_res.full     = &w_masked;
        o_res.zero_pos = w_pos;
    end

endmodule

`default_nettype wire
